// ===== design/dq_pkg.sv =====
// Shared types and constants for the double-ended queue block.
`timescale 1ns / 1ps

package dq_pkg;

    // Fixed port widths
    localparam int OP_W      = 3;
    localparam int VAL_W     = 32;
    localparam int CNT_OUT_W = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_R = 3'd0;
    localparam logic [OP_W-1:0] OP_POP_L  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_R  = 3'd2;
    localparam logic [OP_W-1:0] OP_PEEK_L = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK_R = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the incoming beat
        logic exec;   // run the operation: memory access and pointer update
    } t_dq_cmd;

endpackage

// ===== design/dq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dq_ram #(
    parameter int W = 32,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/dq_ctrl.sv =====
// Controller state machine for the double-ended queue.
`timescale 1ns / 1ps

module dq_ctrl
    import dq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    output logic    o_busy,
    output logic    o_valid,
    output t_dq_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    // A new beat may be taken while the previous result is shown
    assign w_accept = i_start && (r_state != S_EXEC);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                n_state = w_accept ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Outputs and commands
    assign o_busy     = (r_state == S_EXEC);
    assign o_valid    = (r_state == S_RESP);
    assign o_cmd.load = w_accept;
    assign o_cmd.exec = (r_state == S_EXEC);

endmodule

// ===== design/dq_datapath.sv =====
// Datapath: ring pointers, entry count, fault decode and entry memory.
`timescale 1ns / 1ps

module dq_datapath
    import dq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dq_cmd              i_cmd,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [VAL_W-1:0]     i_push_value,
    output logic [VAL_W-1:0]     o_read_value,
    output logic                 o_now_empty,
    output logic [CNT_OUT_W-1:0] o_entry_count,
    output logic                 o_fault
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    // Captured beat
    logic [OP_W-1:0]  r_op;
    logic [VAL_W-1:0] r_push_value;

    // Queue state
    logic [AW-1:0] r_left;
    logic [AW-1:0] r_right;
    logic [CW-1:0] r_count;

    // Result flags
    logic r_rd_ok;
    logic r_fault;

    // Decode and memory controls
    logic          w_is_push, w_is_left, w_is_right, w_is_pop, w_known;
    logic          w_empty, w_full, w_fault;
    logic          w_we, w_re;
    logic [AW-1:0] w_left_fwd, w_right_fwd, w_right_back, w_raddr;
    logic [WIDTH-1:0] w_wdata, w_rdata;

    // Capture the beat on accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op         <= i_operation;
            r_push_value <= i_push_value;
        end
    end

    // Operation decode
    always_comb begin
        w_is_push  = (r_op == OP_PUSH_R);
        w_is_left  = (r_op == OP_POP_L) || (r_op == OP_PEEK_L);
        w_is_right = (r_op == OP_POP_R) || (r_op == OP_PEEK_R);
        w_is_pop   = (r_op == OP_POP_L) || (r_op == OP_POP_R);
        w_known    = w_is_push || w_is_left || w_is_right;
        w_empty    = (r_count == '0);
        w_full     = (r_count == CNT_FULL);
        w_fault    = !w_known || (w_is_push && w_full)
                     || ((w_is_left || w_is_right) && w_empty);
    end

    // Pointer steps, wrapping at DEPTH
    assign w_left_fwd   = (r_left == PTR_LAST) ? '0 : r_left + AW'(1);
    assign w_right_fwd  = (r_right == PTR_LAST) ? '0 : r_right + AW'(1);
    assign w_right_back = (r_right == '0) ? PTR_LAST : r_right - AW'(1);

    // Memory access during execute
    assign w_we    = i_cmd.exec && w_is_push && !w_fault;
    assign w_re    = i_cmd.exec && (w_is_left || w_is_right) && !w_fault;
    assign w_raddr = w_is_left ? r_left : w_right_back;
    assign w_wdata = WIDTH'(r_push_value);

    dq_ram #(
        .W (WIDTH),
        .D (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_right),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Pointer and count update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_right <= '0;
            r_count <= '0;
        end else if (i_cmd.exec && !w_fault) begin
            if (w_is_push) begin
                r_right <= w_right_fwd;
                r_count <= r_count + CW'(1);
            end else if (w_is_pop) begin
                if (w_is_left) begin
                    r_left <= w_left_fwd;
                end else begin
                    r_right <= w_right_back;
                end
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Result flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ok <= 1'b0;
            r_fault <= 1'b0;
        end else if (i_cmd.exec) begin
            r_rd_ok <= w_re;
            r_fault <= w_fault;
        end
    end

    // Result beat
    assign o_read_value  = r_rd_ok ? VAL_W'(w_rdata) : '0;
    assign o_now_empty   = (r_count == '0);
    assign o_entry_count = CNT_OUT_W'(r_count);
    assign o_fault       = r_fault;

endmodule

// ===== design/double_ended_queue_top.sv =====
// The result strobe comes in the response state, which follows the execute state
// entered at the accept edge. The block takes no new beat while executing; a new
// beat is taken in the cycle that shows the previous result.
// Reset (synchronous, active low) empties the queue: pointers and count clear;
// memory contents are not cleared, and no clearing pass is run.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module double_ended_queue_top
    import dq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [VAL_W-1:0]     i_push_value,
    output logic                 o_valid,
    output logic [VAL_W-1:0]     o_read_value,
    output logic                 o_now_empty,
    output logic [CNT_OUT_W-1:0] o_entry_count,
    output logic                 o_fault
);

    t_dq_cmd w_cmd;

    // Sequencing
    dq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_cmd   (w_cmd)
    );

    // Queue storage and bookkeeping
    dq_datapath #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_operation   (i_operation),
        .i_push_value  (i_push_value),
        .o_read_value  (o_read_value),
        .o_now_empty   (o_now_empty),
        .o_entry_count (o_entry_count),
        .o_fault       (o_fault)
    );

endmodule

// ===== design/dq_checker.sv =====
// Port-level checks for the double-ended queue, bound to the top level.
`timescale 1ns / 1ps

module dq_checker
    import dq_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_valid,
    input logic [VAL_W-1:0]     o_read_value,
    input logic                 o_now_empty,
    input logic [CNT_OUT_W-1:0] o_entry_count,
    input logic                 o_fault
);

    // An accepted beat makes the block busy for the execute cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // Every execute cycle is followed by exactly one result beat
    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_valid && !busy))
        else $error("no result beat after execute");

    // No result is shown while busy
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat during execute");

    // A faulting operation reads nothing
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fault) |-> (o_read_value == '0))
        else $error("fault beat carries a nonzero value");

    // Empty queue reports a zero count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_now_empty) |-> (o_entry_count == '0))
        else $error("empty queue with nonzero count");

endmodule

bind double_ended_queue_top dq_checker u_dq_checker (.*);

// ===== tb/tb.sv =====
// Testbench for the double-ended queue: directed table plus random beats, checked by a predictor.
`timescale 1ns / 1ps

module tb;
    import dq_pkg::*;

    localparam int DQ_DEPTH = 16;
    localparam int PTR_W    = $clog2(DQ_DEPTH);
    localparam int RANDOM_BEATS = 1125;
    localparam int CYCLE_LIMIT  = 100000;

    // Codes the block does not define; they must fault
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [VAL_W-1:0]     read_value;
        logic                 now_empty;
        logic [CNT_OUT_W-1:0] entry_count;
        logic                 fault;
    } t_dq_result;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] value;
        logic [4:0]       reps;
        logic             typed;
        t_dq_result       res;
    } t_stim_row;

    typedef enum logic [1:0] {MIX_BALANCED, MIX_FILL, MIX_DRAIN} t_op_mix;

    // Directed table; typed results only where they are obvious
    localparam int N_ROWS = 12;
    localparam t_stim_row DIRECTED_ROWS [0:N_ROWS-1] = '{
        '{OP_PEEK_L,    32'h0,         5'd1,  1'b1, '{32'h0,         1'b1, 5'd0,  1'b1}},
        '{OP_POP_R,     32'h0,         5'd1,  1'b1, '{32'h0,         1'b1, 5'd0,  1'b1}},
        '{OP_UNUSED_LO, 32'hFFFF_FFFF, 5'd1,  1'b1, '{32'h0,         1'b1, 5'd0,  1'b1}},
        '{OP_UNUSED_HI, 32'h0,         5'd1,  1'b1, '{32'h0,         1'b1, 5'd0,  1'b1}},
        '{OP_PUSH_R,    32'h0,         5'd1,  1'b1, '{32'h0,         1'b0, 5'd1,  1'b0}},
        '{OP_PUSH_R,    32'hFFFF_FFFF, 5'd1,  1'b1, '{32'h0,         1'b0, 5'd2,  1'b0}},
        '{OP_PEEK_L,    32'h0,         5'd1,  1'b1, '{32'h0,         1'b0, 5'd2,  1'b0}},
        '{OP_PEEK_R,    32'h0,         5'd1,  1'b1, '{32'hFFFF_FFFF, 1'b0, 5'd2,  1'b0}},
        '{OP_PUSH_R,    32'h1357_9BDF, 5'd14, 1'b0, '0},
        '{OP_PUSH_R,    32'hDEAD_BEEF, 5'd1,  1'b1, '{32'h0,         1'b0, 5'd16, 1'b1}},
        '{OP_POP_L,     32'h0,         5'd1,  1'b1, '{32'h0,         1'b0, 5'd15, 1'b0}},
        '{OP_POP_R,     32'h0,         5'd1,  1'b0, '0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [OP_W-1:0]      i_operation;
    logic [VAL_W-1:0]     i_push_value;
    logic                 o_valid;
    logic [VAL_W-1:0]     o_read_value;
    logic                 o_now_empty;
    logic [CNT_OUT_W-1:0] o_entry_count;
    logic                 o_fault;

    // Typed expectation travels with the beat
    logic       beat_typed;
    t_dq_result beat_typed_res;

    double_ended_queue_top #(.DEPTH(DQ_DEPTH), .WIDTH(VAL_W)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_push_value  (i_push_value),
        .o_valid       (o_valid),
        .o_read_value  (o_read_value),
        .o_now_empty   (o_now_empty),
        .o_entry_count (o_entry_count),
        .o_fault       (o_fault)
    );

    // Shadow deque state
    logic [VAL_W-1:0]     shadow_slots [DQ_DEPTH];
    logic [PTR_W-1:0]     left_idx     = '0;
    logic [PTR_W-1:0]     right_idx    = '0;
    logic [CNT_OUT_W-1:0] shadow_count = '0;

    t_dq_result expected_results [$];
    int         error_count = 0;
    int         cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run one operation on the shadow deque and return its result
    function automatic t_dq_result apply_deque_op(logic [OP_W-1:0] op, logic [VAL_W-1:0] value);
        t_dq_result r;
        logic [PTR_W-1:0] last_idx;
        r = '0;
        last_idx = right_idx - 1'b1;
        case (op)
            OP_PUSH_R: begin
                if (shadow_count >= DQ_DEPTH) begin
                    r.fault = 1'b1;
                end else begin
                    shadow_slots[right_idx] = value;
                    right_idx = right_idx + 1'b1;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            OP_POP_L, OP_PEEK_L: begin
                if (shadow_count == 0) begin
                    r.fault = 1'b1;
                end else begin
                    r.read_value = shadow_slots[left_idx];
                    if (op == OP_POP_L) begin
                        left_idx = left_idx + 1'b1;
                        shadow_count = shadow_count - 1'b1;
                    end
                end
            end
            OP_POP_R, OP_PEEK_R: begin
                if (shadow_count == 0) begin
                    r.fault = 1'b1;
                end else begin
                    r.read_value = shadow_slots[last_idx];
                    if (op == OP_POP_R) begin
                        right_idx = last_idx;
                        shadow_count = shadow_count - 1'b1;
                    end
                end
            end
            default: r.fault = 1'b1;
        endcase
        r.now_empty = (shadow_count == 0);
        r.entry_count = shadow_count;
        return r;
    endfunction

    // Compare one result beat with the oldest expectation
    task automatic check_result(t_dq_result want);
        if (o_read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, o_read_value);
            error_count++;
        end
        if (o_now_empty !== want.now_empty) begin
            $error("now_empty: expected %b, got %b", want.now_empty, o_now_empty);
            error_count++;
        end
        if (o_entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, o_entry_count);
            error_count++;
        end
        if (o_fault !== want.fault) begin
            $error("fault: expected %b, got %b", want.fault, o_fault);
            error_count++;
        end
    endtask

    // Monitor: check results, then predict for the beat taken at this edge
    always @(posedge i_clk) begin
        t_dq_result predicted;
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no expectation pending");
                    error_count++;
                end else begin
                    check_result(expected_results.pop_front());
                end
            end
            if (start && !busy) begin
                predicted = apply_deque_op(i_operation, i_push_value);
                expected_results.insert(expected_results.size(),
                                        beat_typed ? beat_typed_res : predicted);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Present one beat and hold it until the block takes it
    task automatic send_beat(logic [OP_W-1:0] op, logic [VAL_W-1:0] value,
                             logic typed, t_dq_result res);
        start          <= 1'b1;
        i_operation    <= op;
        i_push_value   <= value;
        beat_typed     <= typed;
        beat_typed_res <= res;
        do @(posedge i_clk); while (busy);
    endtask

    // Idle the sender with junk on the payload
    task automatic hold_off(int cycles);
        repeat (cycles) begin
            start        <= 1'b0;
            i_operation  <= OP_W'($urandom);
            i_push_value <= $urandom;
            @(posedge i_clk);
        end
    endtask

    // Stop sending until every expected result has come back
    task automatic drain_results();
        hold_off(1);
        while (expected_results.size() != 0) hold_off(1);
    endtask

    function automatic logic [OP_W-1:0] pick_op(t_op_mix mix);
        int roll;
        int push_pct;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  push_pct = 75;
            MIX_DRAIN: push_pct = 20;
            default:   push_pct = 45;
        endcase
        if (roll < 3) return OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        if (roll < 3 + push_pct) return OP_PUSH_R;
        return OP_W'($urandom_range(OP_POP_L, OP_PEEK_R));
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return $urandom;
    endfunction

    // Stimulus
    initial begin
        t_op_mix mix;
        int      sent;
        int      burst_left;
        mix            = MIX_BALANCED;
        burst_left     = 0;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_operation    <= OP_PUSH_R;
        i_push_value   <= '0;
        beat_typed     <= 1'b0;
        beat_typed_res <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part
        foreach (DIRECTED_ROWS[i]) begin
            for (int rep = 0; rep < DIRECTED_ROWS[i].reps; rep++) begin
                send_beat(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].value + rep,
                          DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
            end
        end
        drain_results();

        // Random part: phases lean toward filling or draining to hit both ends
        for (sent = 0; sent < RANDOM_BEATS; sent++) begin
            if (sent % 40 == 0) mix = t_op_mix'($urandom_range(0, 2));
            if (sent == 600) drain_results();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                // back-to-back stretch with no sender gaps
                if (sent < 300 || sent >= 500) hold_off($urandom_range(0, 6));
            end
            burst_left--;
            send_beat(pick_op(mix), pick_value(), 1'b0, '0);
        end

        // Wind down
        drain_results();
        hold_off(4);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
        end
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
